### rtl/mavw_pkg.sv
// ----------------------------------------------------------------------------
// Moving average window package
// Shared widths, command codes and the command item passed front to back.
// ----------------------------------------------------------------------------
package mavw_pkg;

   localparam int unsigned WINDOW_DEFAULT = 16;
   localparam int unsigned SAMPLE_W       = 8;
   localparam int unsigned SAMPLE_MAX     = 255;
   localparam int unsigned QUEUE_DEPTH    = 2;

   // op field codes on the request channel
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic {
      CMD_ADD   = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [SAMPLE_W-1:0] sample;
   } cmd_type;

   // head of the command queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

### rtl/mavw_if.sv
// ----------------------------------------------------------------------------
// Moving average window channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface mavw_req_if
   import mavw_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                op;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output op, output sample, input ready);
   modport sink   (input valid, input op, input sample, output ready);
endinterface

interface mavw_rsp_if
   import mavw_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

### rtl/mavw_front.sv
// ----------------------------------------------------------------------------
// Moving average window front end
// Takes request items, decodes op into a command and holds it for the queue.
// ----------------------------------------------------------------------------
module mavw_front
   import mavw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mavw_req_if.sink   req_chan,
   output cmd_type    front_cmd,
   output logic       front_valid,
   input  logic       front_ready
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   logic    accept;

   assign req_chan.ready = !hold_valid_ff || front_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      if (accept) begin
         hold_valid_in      = 1'b1;
         hold_cmd_in.kind   = (req_chan.op == OP_CLEAR) ? CMD_CLEAR : CMD_ADD;
         hold_cmd_in.sample = req_chan.sample;
      end else if (front_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

   assign front_cmd   = hold_cmd_ff;
   assign front_valid = hold_valid_ff;

endmodule

### rtl/mavw_queue.sv
// ----------------------------------------------------------------------------
// Moving average window command queue
// Small FIFO between front end and back end.
// ----------------------------------------------------------------------------
module mavw_queue
   import mavw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cmd_type        push_cmd,
   input  logic           push_valid,
   output logic           push_ready,
   output queue_head_type q_head,
   input  logic           pop
);

   localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready   = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign do_push      = push_valid && push_ready;
   assign do_pop       = pop && (count_ff != '0);
   assign q_head.valid = (count_ff != '0);
   assign q_head.cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // occupancy never exceeds the storage
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy out of range");

endmodule

### rtl/mavw_back.sv
// ----------------------------------------------------------------------------
// Moving average window back end
// Ring store, running sum, fill count and a bit-serial divider.
// ----------------------------------------------------------------------------
module mavw_back
   import mavw_pkg::*;
#(
   parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type q_head,
   output logic           pop,
   mavw_rsp_if.source     rsp_chan
);

   localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
   localparam int unsigned SUM_W  = $clog2(SAMPLE_MAX * WINDOW + 1);
   localparam int unsigned STEP_W = $clog2(SUM_W + 1);
   localparam int unsigned CHK_W  = CNT_W + SAMPLE_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV
   } state_type;

   state_type           state_ff, state_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SAMPLE_W-1:0] cur_sample_ff, cur_sample_in;
   logic [SUM_W-1:0]    dividend_ff, dividend_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    quot_ff, quot_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SAMPLE_W-1:0] result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // ring store, entries that were never written since clear read as zero
   logic [SAMPLE_W-1:0] ring_mem [WINDOW];
   logic [WINDOW-1:0]   ring_valid_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rd_valid_ff;

   logic                mem_re, mem_we, ring_clear, out_free, take;
   logic [SAMPLE_W-1:0] old_sample;
   logic [CNT_W:0]      trial, trial_diff;
   logic [SUM_W-1:0]    quot_next;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign old_sample = rd_valid_ff ? rd_data_ff : '0;
   assign trial      = {rem_ff, dividend_ff[SUM_W-1]};
   assign take       = (trial >= {1'b0, count_ff});
   assign trial_diff = trial - {1'b0, count_ff};
   assign quot_next  = {quot_ff[SUM_W-2:0], take};

   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      cur_sample_in = cur_sample_ff;
      dividend_in   = dividend_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      ring_clear    = 1'b0;
      pop           = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               if (q_head.cmd.kind == CMD_CLEAR) begin
                  if (out_free) begin
                     pop          = 1'b1;
                     ring_clear   = 1'b1;
                     sum_in       = '0;
                     ptr_in       = '0;
                     count_in     = '0;
                     result_in    = '0;
                     rsp_valid_in = 1'b1;
                  end
               end else begin
                  pop           = 1'b1;
                  mem_re        = 1'b1;
                  cur_sample_in = q_head.cmd.sample;
                  state_in      = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            mem_we      = 1'b1;
            sum_in      = sum_ff - SUM_W'(old_sample) + SUM_W'(cur_sample_ff);
            ptr_in      = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
            count_in    = (count_ff == CNT_W'(WINDOW)) ? count_ff : count_ff + 1'b1;
            dividend_in = sum_in;
            rem_in      = '0;
            quot_in     = '0;
            step_in     = STEP_W'(SUM_W);
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            // last step waits for a free output register
            if (step_ff != STEP_W'(1) || out_free) begin
               dividend_in = dividend_ff << 1;
               rem_in      = take ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
               quot_in     = quot_next;
               step_in     = step_ff - 1'b1;
               if (step_ff == STEP_W'(1)) begin
                  result_in    = quot_next[SAMPLE_W-1:0];
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         ptr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_sample_ff <= cur_sample_in;
      dividend_ff   <= dividend_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      step_ff       <= step_in;
      result_ff     <= result_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[ptr_ff] <= cur_sample_ff;
      end
      if (mem_re) begin
         rd_data_ff  <= ring_mem[ptr_ff];
         rd_valid_ff <= ring_valid_ff[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ring_clear) begin
         ring_valid_ff <= '0;
      end else if (mem_we) begin
         ring_valid_ff[ptr_ff] <= 1'b1;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.average = result_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW))
      else $error("fill count above window size");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> count_ff != '0)
      else $error("division by empty window");

   assert property (@(posedge clock) disable iff (reset)
      CHK_W'(sum_ff) <= {count_ff, SAMPLE_W'(0)})
      else $error("running sum exceeds fill count bound");

   assert property (@(posedge clock) disable iff (reset)
      pop && q_head.cmd.kind == CMD_CLEAR |=>
         sum_ff == '0 && count_ff == '0 && ptr_ff == '0 && ring_valid_ff == '0)
      else $error("clear did not empty the window");

endmodule

### rtl/moving_average_window.sv
// ----------------------------------------------------------------------------
// Moving average window
// Running mean over the last WINDOW 8-bit samples, with a clear command.
// ----------------------------------------------------------------------------
// Add item path: front register, queue, ring read, sum update, SUM_W divide steps.
// The divider makes one quotient bit a cycle, its last step waiting for a free
//   output register; no new item is taken until the divide ends. A clear item
//   finishes in the idle state once the output register is free.
// Reset (synchronous): window empty, sum, pointer and count zero, queue empty.
// ----------------------------------------------------------------------------
module moving_average_window
   import mavw_pkg::*;
#(
   parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mavw_req_if.sink   req_chan,
   mavw_rsp_if.source rsp_chan
);

   // front end -> queue
   cmd_type        front_cmd;
   logic           front_valid;
   logic           front_ready;

   // queue -> back end
   queue_head_type q_head;
   logic           pop;

   // Front end: one register stage, decodes op into an add or clear command.
   mavw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .front_cmd   (front_cmd),
      .front_valid (front_valid),
      .front_ready (front_ready)
   );

   // Two-entry queue so intake keeps going while the divider is busy.
   mavw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (front_cmd),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .q_head     (q_head),
      .pop        (pop)
   );

   // Back end: ring store read/update, running sum, restoring divide by the
   // fill count, result held in an output register until taken.
   mavw_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Moving average window testbench
// Drives add and clear items with random gaps and receiver stalls, predicts
// each average with a software copy of the window and checks every response.
// ----------------------------------------------------------------------------
module testbench;
   import mavw_pkg::*;

   localparam int unsigned WIN         = WINDOW_DEFAULT;
   localparam int unsigned PTR_W       = $clog2(WIN);
   localparam int unsigned FILL_W      = $clog2(WIN + 1);
   localparam int unsigned SUM_W       = $clog2(SAMPLE_MAX * WIN + 1);
   localparam int          RANDOM_CMDS = 2000;
   localparam int          HOLD_CYCLES = 400;
   localparam int          HOLD_AT_A   = 300;
   localparam int          HOLD_AT_B   = 1300;
   localparam int          TAIL_CYCLES = 40;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          SHOW_ERRORS = 10;

   // one queued item; wait_idle holds it back until all averages are in
   typedef struct {
      cmd_type cmd;
      bit      wait_idle;
   } backlog_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mavw_req_if req_chan ();
   mavw_rsp_if rsp_chan ();

   moving_average_window uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Window model: ring of samples, running sum, write slot and fill count.
   // ------------------------------------------------------------------------
   logic [SAMPLE_W-1:0] win_ring [WIN];
   logic [SUM_W-1:0]    win_sum;
   logic [PTR_W-1:0]    win_slot;
   logic [FILL_W-1:0]   win_fill;

   backlog_entry_type   cmd_backlog [$];
   logic [SAMPLE_W-1:0] avg_expected [$];

   // counters shared between processes are only written with NBAs
   int accepted_count = 0;
   int results_seen   = 0;
   int cycle_count    = 0;

   int mismatch_count = 0;
   int add_count      = 0;
   int clear_count    = 0;
   int holds_done     = 0;

   // Applies one item to the window model and returns the average it yields.
   function automatic logic [SAMPLE_W-1:0] window_mean_step(input cmd_type c);
      logic [SUM_W-1:0] quot;
      if (c.kind == CMD_CLEAR) begin
         foreach (win_ring[i]) win_ring[i] = '0;
         win_sum  = '0;
         win_slot = '0;
         win_fill = '0;
         return '0;
      end
      // slot being replaced holds zero on the first pass
      win_sum            = win_sum - SUM_W'(win_ring[win_slot]) + SUM_W'(c.sample);
      win_ring[win_slot] = c.sample;
      win_slot           = (win_slot == PTR_W'(WIN - 1)) ? '0 : win_slot + 1'b1;
      if (win_fill < FILL_W'(WIN))
         win_fill = win_fill + 1'b1;
      quot = win_sum / SUM_W'(win_fill);
      return quot[SAMPLE_W-1:0];
   endfunction

   task automatic flag_error(input string what);
      if (mismatch_count < SHOW_ERRORS)
         $display("[%0t] ERROR: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic queue_cmd(input cmd_kind_type kind, input logic [SAMPLE_W-1:0] s,
                            input bit wait_idle);
      backlog_entry_type e;
      e.cmd.kind   = kind;
      e.cmd.sample = s;
      e.wait_idle  = wait_idle;
      cmd_backlog.push_back(e);
   endtask

   // extremes show up often, the rest is uniform
   function automatic logic [SAMPLE_W-1:0] random_sample();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0: return '0;
         1: return SAMPLE_W'(SAMPLE_MAX);
         2: return $urandom_range(0, 1) ? SAMPLE_W'(1) : SAMPLE_W'(SAMPLE_MAX - 1);
         default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Sender: offers items from the backlog, random gaps between them.
   // ------------------------------------------------------------------------
   cmd_type cur_cmd;
   int      tx_gap_left    = 0;
   int      tx_steady_left = 0;

   // mostly short gaps, a few long ones, now and then a run without any
   function automatic int next_tx_gap();
      int roll;
      if (tx_steady_left > 0) begin
         tx_steady_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         tx_steady_left = $urandom_range(30, 80);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      bit                fire;
      int                in_flight;
      backlog_entry_type next_entry;
      if (reset) begin
         req_chan.valid <= 1'b0;
         tx_gap_left = 0;
         // model window empty out of reset
         foreach (win_ring[i]) win_ring[i] = '0;
         win_sum  = '0;
         win_slot = '0;
         win_fill = '0;
      end else begin
         fire = req_chan.valid && req_chan.ready;
         if (fire) begin
            avg_expected.push_back(window_mean_step(cur_cmd));
            accepted_count <= accepted_count + 1;
            if (cur_cmd.kind == CMD_CLEAR) clear_count++;
            else add_count++;
            tx_gap_left = next_tx_gap();
         end
         // results_seen is last cycle's value; a drain may then wait for its update
         in_flight = accepted_count + int'(fire) - results_seen;
         if (!req_chan.valid || fire) begin
            if (tx_gap_left > 0) begin
               tx_gap_left--;
               req_chan.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0 &&
                         !(cmd_backlog[0].wait_idle && in_flight > 0)) begin
               next_entry = cmd_backlog.pop_front();
               cur_cmd    = next_entry.cmd;
               req_chan.valid  <= 1'b1;
               req_chan.op     <= cur_cmd.kind;
               req_chan.sample <= cur_cmd.sample;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls, two long hold-offs to back the block up.
   // ------------------------------------------------------------------------
   int rx_stall_left  = 0;
   int rx_steady_left = 0;
   int hold_left      = 0;

   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      int                  roll;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_stall_left = 0;
         hold_left     = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (avg_expected.size() == 0) begin
               flag_error($sformatf("response %0d (average %0d) with nothing expected",
                                    results_seen, rsp_chan.average));
            end else begin
               want = avg_expected.pop_front();
               if (rsp_chan.average !== want)
                  flag_error($sformatf("response %0d: average expected %0d, got %0d",
                                       results_seen, want, rsp_chan.average));
            end
            results_seen <= results_seen + 1;
            if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) begin
               hold_left = HOLD_CYCLES;
               holds_done++;
            end
         end

         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rx_steady_left > 0) begin
            rx_steady_left--;
            rsp_chan.ready <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               rx_steady_left = $urandom_range(200, 600);
               rsp_chan.ready <= 1'b1;
            end else if (roll < 22) begin
               rx_stall_left = (roll < 21) ? $urandom_range(0, 3) : $urandom_range(20, 40);
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items in, %0d responses out",
                  cycle_count, accepted_count, results_seen);
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int           n_total;
      int           missing;
      cmd_kind_type kind;

      // full-scale samples: first pass over zeros, then count saturation,
      // pointer wrap and the largest running sum
      repeat (WIN + 1) queue_cmd(CMD_ADD, SAMPLE_W'(SAMPLE_MAX), 1'b0);
      // clear ignores its sample field
      queue_cmd(CMD_CLEAR, 8'h5A, 1'b0);
      queue_cmd(CMD_ADD, 8'd0, 1'b0);
      queue_cmd(CMD_ADD, 8'd1, 1'b0);
      queue_cmd(CMD_ADD, SAMPLE_W'(SAMPLE_MAX - 1), 1'b0);
      // two clears in a row, the second on an already empty window
      queue_cmd(CMD_CLEAR, 8'hFF, 1'b0);
      queue_cmd(CMD_CLEAR, 8'h00, 1'b0);

      // random part: clears are rare so the window fills and wraps often
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         kind = ($urandom_range(0, 99) < 3) ? CMD_CLEAR : CMD_ADD;
         queue_cmd(kind, random_sample(), (i == 600 || i == 1500));
      end
      n_total = cmd_backlog.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != n_total || results_seen < n_total)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      missing = avg_expected.size();
      if (missing != 0)
         $display("%0d expected averages never arrived", missing);
      $display("%0d adds and %0d clears checked over %0d responses in %0d cycles",
               add_count, clear_count, results_seen, cycle_count);
      $display("%0d long receiver hold-offs, %0d errors", holds_done,
               mismatch_count + missing);
      if (mismatch_count == 0 && missing == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/mavw_pkg.sv
rtl/mavw_if.sv
rtl/mavw_front.sv
rtl/mavw_queue.sv
rtl/mavw_back.sv
rtl/moving_average_window.sv
tb/testbench.sv
